// ===== src/utcal_pkg.sv =====
// constants, types and tables shared by the unix time to calendar pipeline
package utcal_pkg;

	// time of day
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;

	// julian day handling: epoch day plus the gregorian offset
	localparam int unsigned EPOCH_JDN     = 2440588;
	localparam int unsigned JDN_OFFSET    = 32044;
	localparam int unsigned DAY_BASE      = EPOCH_JDN + JDN_OFFSET;
	localparam int unsigned DAYS_PER_400Y = 146097;
	localparam int unsigned DAYS_PER_4Y   = 1461;
	localparam int unsigned YEAR_OFFSET   = 4800;
	localparam int unsigned DAYS_PER_WEEK = 7;
	localparam int unsigned WDAY_BIAS     = EPOCH_JDN % DAYS_PER_WEEK;

	// months counted from march: index at which the year rolls over
	localparam int unsigned MONTH_LATE    = 10;
	localparam int unsigned MONTHS_M      = 12;

	// reciprocals for the constant dividers, quotient estimate = (x * r) >> shift
	localparam int unsigned DAY_SHIFT     = 32;
	localparam int unsigned DAY_RECIP     = 49710;
	localparam int unsigned HOUR_SHIFT    = 17;
	localparam int unsigned HOUR_RECIP    = (1 << HOUR_SHIFT) / SECS_PER_HOUR;
	localparam int unsigned MIN_SHIFT     = 12;
	localparam int unsigned MIN_RECIP     = (1 << MIN_SHIFT) / SECS_PER_MIN;
	localparam int unsigned WDAY_SHIFT    = 16;
	localparam int unsigned WDAY_RECIP    = (1 << WDAY_SHIFT) / DAYS_PER_WEEK;
	localparam int unsigned CENT_SHIFT    = 24;
	localparam int unsigned CENT_RECIP    = (1 << CENT_SHIFT) / DAYS_PER_400Y;
	localparam int unsigned YR4_SHIFT     = 18;
	localparam int unsigned YR4_RECIP     = (1 << YR4_SHIFT) / DAYS_PER_4Y;

	// time of day fields that ride along with the date
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} tod_t;

	// first day of each march-based month within the year, (153 * m + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== src/unix_time_to_calendar.sv =====
// unix seconds to gregorian date, time of day and weekday, ten stage pipeline
//
// Takes one 32-bit count of seconds since 1970-01-01 00:00:00 per cycle while
// the pipeline is not stalled and returns year, month, day of month, hour,
// minute, second and weekday (0 is Monday). Every divider is a constant
// reciprocal multiply followed in the next stage by a single compare and
// subtract, and the whole chain is spread over ten stages. The whole pipeline
// advances together and holds while a finished result sits stalled at the
// output, so in_stall follows out_stall only while out_valid is high. No time
// zone is applied and every input value is a valid time. Nothing needs
// clearing after reset besides the stage valid bits.
module unix_time_to_calendar
	import utcal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] seconds_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday
);

	// pipeline advance
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			out_valid <= v_s9;
		end
	end

	// stage 1: day count estimate
	logic [47:0] day_prod;
	logic [31:0] secs_s1;
	logic [15:0] dq_s1;
	assign day_prod = 48'(seconds_count) * 48'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= seconds_count;
			dq_s1   <= day_prod[DAY_SHIFT +: 16];
		end
	end

	// stage 2: day count correction and seconds of day
	logic [32:0] day_rem;
	logic        day_fix;
	logic [15:0] day_s2;
	logic [16:0] sod_s2;
	assign day_rem = 33'(secs_s1) - 33'(dq_s1) * 33'(SECS_PER_DAY);
	assign day_fix = day_rem[17:0] >= 18'(SECS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en) begin
			day_s2 <= dq_s1 + 16'(day_fix);
			sod_s2 <= day_fix ? 17'(day_rem[17:0] - 18'(SECS_PER_DAY)) : day_rem[16:0];
		end
	end

	// stage 3: shifted day number, century, hour and weekday estimates
	logic [21:0] a_day;
	logic [31:0] cent_prod;
	logic [22:0] hour_prod;
	logic [15:0] wx_day;
	logic [29:0] wday_prod;
	logic [21:0] a_s3;
	logic [6:0]  bq_s3;
	logic [16:0] sod_s3;
	logic [4:0]  hq_s3;
	logic [15:0] wx_s3;
	logic [12:0] wq_s3;
	assign a_day     = 22'(day_s2) + 22'(DAY_BASE);
	assign cent_prod = 32'({a_day, 2'b11}) * 32'(CENT_RECIP);
	assign hour_prod = 23'(sod_s2) * 23'(HOUR_RECIP);
	assign wx_day    = day_s2 + 16'(WDAY_BIAS);
	assign wday_prod = 30'(wx_day) * 30'(WDAY_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= a_day;
			bq_s3  <= cent_prod[CENT_SHIFT +: 7];
			sod_s3 <= sod_s2;
			hq_s3  <= hour_prod[HOUR_SHIFT +: 5];
			wx_s3  <= wx_day;
			wq_s3  <= wday_prod[WDAY_SHIFT +: 13];
		end
	end

	// stage 4: century, hour and weekday corrections
	logic [23:0] cent_rem;
	logic        cent_fix;
	logic [16:0] hour_rem;
	logic        hour_fix;
	logic [15:0] wday_rem;
	logic        wday_fix;
	logic [21:0] a_s4;
	logic [6:0]  b_s4;
	logic [4:0]  hour_s4;
	logic [11:0] soh_s4;
	logic [2:0]  wday_s4;
	assign cent_rem = {a_s3, 2'b11} - 24'(bq_s3) * 24'(DAYS_PER_400Y);
	assign cent_fix = cent_rem >= 24'(DAYS_PER_400Y);
	assign hour_rem = sod_s3 - 17'(hq_s3) * 17'(SECS_PER_HOUR);
	assign hour_fix = hour_rem[12:0] >= 13'(SECS_PER_HOUR);
	assign wday_rem = wx_s3 - 16'(wq_s3) * 16'(DAYS_PER_WEEK);
	assign wday_fix = wday_rem[3:0] >= 4'(DAYS_PER_WEEK);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4    <= a_s3;
			b_s4    <= bq_s3 + 7'(cent_fix);
			hour_s4 <= hq_s3 + 5'(hour_fix);
			soh_s4  <= hour_fix ? 12'(hour_rem[12:0] - 13'(SECS_PER_HOUR)) : hour_rem[11:0];
			wday_s4 <= wday_fix ? 3'(wday_rem[3:0] - 4'(DAYS_PER_WEEK)) : wday_rem[2:0];
		end
	end

	// stage 5: day within century, minute estimate
	logic [23:0] cent_days;
	logic [21:0] c_full;
	logic [18:0] min_prod;
	logic [6:0]  b_s5;
	logic [15:0] c_s5;
	logic [4:0]  hour_s5;
	logic [11:0] soh_s5;
	logic [5:0]  mq_s5;
	logic [2:0]  wday_s5;
	assign cent_days = 24'(b_s4) * 24'(DAYS_PER_400Y);
	assign c_full    = a_s4 - cent_days[23:2];
	assign min_prod  = 19'(soh_s4) * 19'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s5    <= b_s4;
			c_s5    <= c_full[15:0];
			hour_s5 <= hour_s4;
			soh_s5  <= soh_s4;
			mq_s5   <= min_prod[MIN_SHIFT +: 6];
			wday_s5 <= wday_s4;
		end
	end

	// stage 6: four-year cycle estimate, minute and second
	logic [25:0] yr4_prod;
	logic [11:0] min_rem;
	logic        min_fix;
	logic [6:0]  b_s6;
	logic [15:0] c_s6;
	logic [6:0]  dq_s6;
	tod_t        tod_s6;
	assign yr4_prod = 26'({c_s5, 2'b11}) * 26'(YR4_RECIP);
	assign min_rem  = soh_s5 - 12'(mq_s5) * 12'(SECS_PER_MIN);
	assign min_fix  = min_rem[6:0] >= 7'(SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s6           <= b_s5;
			c_s6           <= c_s5;
			dq_s6          <= yr4_prod[YR4_SHIFT +: 7];
			tod_s6.hour    <= hour_s5;
			tod_s6.minute  <= mq_s5 + 6'(min_fix);
			tod_s6.second  <= min_fix ? 6'(min_rem[6:0] - 7'(SECS_PER_MIN)) : min_rem[5:0];
			tod_s6.weekday <= wday_s5;
		end
	end

	// stage 7: four-year cycle correction
	logic [17:0] yr4_rem;
	logic        yr4_fix;
	logic [6:0]  b_s7;
	logic [15:0] c_s7;
	logic [6:0]  d_s7;
	tod_t        tod_s7;
	assign yr4_rem = {c_s6, 2'b11} - 18'(dq_s6) * 18'(DAYS_PER_4Y);
	assign yr4_fix = yr4_rem >= 18'(DAYS_PER_4Y);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s7   <= b_s6;
			c_s7   <= c_s6;
			d_s7   <= dq_s6 + 7'(yr4_fix);
			tod_s7 <= tod_s6;
		end
	end

	// stage 8: day within year and year before the march rollover
	logic [17:0] yr4_days;
	logic [15:0] e_full;
	logic [13:0] yr_full;
	logic [8:0]  e_s8;
	logic [11:0] yr_s8;
	tod_t        tod_s8;
	assign yr4_days = 18'(d_s7) * 18'(DAYS_PER_4Y);
	assign e_full   = c_s7 - yr4_days[17:2];
	assign yr_full  = 14'(b_s7) * 14'd100 + 14'(d_s7) - 14'(YEAR_OFFSET);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s8   <= e_full[8:0];
			yr_s8  <= yr_full[11:0];
			tod_s8 <= tod_s7;
		end
	end

	// stage 9: month search over the month start table
	logic [3:0]  m_sel;
	logic [8:0]  e_s9;
	logic [3:0]  m_s9;
	logic [11:0] yr_s9;
	tod_t        tod_s9;

	always_comb begin
		m_sel = '0;
		for (int k = 1; k < MONTHS_M; k++) begin
			if (e_s8 >= month_start(4'(k))) begin
				m_sel = 4'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s9   <= e_s8;
			m_s9   <= m_sel;
			yr_s9  <= yr_s8;
			tod_s9 <= tod_s8;
		end
	end

	// stage 10: calendar month, day of month and year, output register
	logic       late;
	logic [8:0] mday_full;
	assign late      = m_s9 >= 4'(MONTH_LATE);
	assign mday_full = e_s9 - month_start(m_s9) + 9'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			year         <= yr_s9 + 12'(late);
			month        <= late ? m_s9 - 4'(MONTH_LATE - 1) : m_s9 + 4'(MONTHS_M - MONTH_LATE + 1);
			day_of_month <= mday_full[4:0];
			hour         <= tod_s9.hour;
			minute       <= tod_s9.minute;
			second       <= tod_s9.second;
			weekday      <= tod_s9.weekday;
		end
	end

	// date fields stay within the calendar
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0
			&& year >= 12'd1970 && year <= 12'd2106))
		else $error("calendar date out of range");

	// time of day and weekday stay within range
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60 && weekday < 3'd7))
		else $error("time of day out of range");

	// corrected remainders stay below their divisors
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (soh_s4 < 12'(SECS_PER_HOUR) && hour_s4 < 5'd24))
		else $error("hour divider correction failed");

endmodule
